>>> sv/fresnel_dielectric_reflectance_defines.svh
// Assertion macros shared by the Fresnel reflectance RTL.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_DEFINES_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_DEFINES_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define FDR_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
// Same-cycle implication.
`define FDR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define FDR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FDR_ASSERT(lbl, cond)
`define FDR_ASSERT_IMP(lbl, ante, cons)
`define FDR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/fdr_pkg.sv
// Types and fixed constants of the Fresnel reflectance block.
// Depends on nothing.
package fdr_pkg;
	localparam int ETA_W  = 16;
	localparam int COS_W  = 18;
	localparam int REFL_W = 17;
	localparam int FRAC_OUT = 16;
	localparam logic [REFL_W-1:0] REFL_ONE = 17'h10000;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_ETA_OUTSIDE = 1'b0,
		REG_ETA_INSIDE  = 1'b1
	} cfg_reg_t;
endpackage

>>> sv/fdr_isqrt.sv
// Pipelined integer square root, one root bit per stage, with a sideband word.
// Depends on nothing.
module fdr_isqrt #(
	parameter int N  = 17,
	parameter int SW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [2*N-1:0] rad,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic [N-1:0]   root,
	output logic [SW-1:0]  out_side
);
	logic           val_q  [N];
	logic [N-1:0]   root_q [N];
	logic [N:0]     rem_q  [N];
	logic [2*N-1:0] rad_q  [N];
	logic [SW-1:0]  side_q [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic           vi;
		logic [N-1:0]   ri;
		logic [N:0]     mi;
		logic [2*N-1:0] di;
		logic [SW-1:0]  si;
		logic [N+2:0]   trial;
		logic [N+2:0]   t;
		logic           ge;

		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign ri = '0;
			assign mi = '0;
			assign di = rad;
			assign si = in_side;
		end else begin : g_next
			assign vi = val_q[k-1];
			assign ri = root_q[k-1];
			assign mi = rem_q[k-1];
			assign di = rad_q[k-1];
			assign si = side_q[k-1];
		end

		// Try to append a one bit to the root.
		always_comb begin
			trial = {mi, di[2*N-1 -: 2]};
			t     = (N+3)'({ri, 2'b01});
			ge    = trial >= t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_q[k] <= 1'b0;
			end else if (en) begin
				val_q[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? (N+1)'(trial - t) : (N+1)'(trial);
				root_q[k] <= {ri[N-2:0], ge};
				rad_q[k]  <= {di[2*N-3:0], 2'b00};
				side_q[k] <= si;
			end
		end
	end

	assign out_valid = val_q[N-1];
	assign root      = root_q[N-1];
	assign out_side  = side_q[N-1];
endmodule

>>> sv/fdr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
// The caller guarantees that the quotient fits in Q bits. Depends on nothing.
module fdr_div #(
	parameter int NW = 33,
	parameter int DW = 16,
	parameter int Q  = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [Q-1:0]  quo,
	output logic [SW-1:0] out_side
);
	logic [NW+DW-1:0] num_ext;
	logic             val_q  [Q];
	logic [DW-1:0]    part_q [Q];
	logic [Q-1:0]     low_q  [Q];
	logic [Q-1:0]     quo_q  [Q];
	logic [DW-1:0]    den_q  [Q];
	logic [SW-1:0]    side_q [Q];

	assign num_ext = (NW+DW)'(num);

	for (genvar k = 0; k < Q; k++) begin : g_stage
		logic          vi;
		logic [DW-1:0] pi;
		logic [Q-1:0]  ni;
		logic [Q-1:0]  qi;
		logic [DW-1:0] di;
		logic [SW-1:0] si;
		logic [DW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign pi = num_ext[Q +: DW];
			assign ni = num[Q-1:0];
			assign qi = '0;
			assign di = den;
			assign si = in_side;
		end else begin : g_next
			assign vi = val_q[k-1];
			assign pi = part_q[k-1];
			assign ni = low_q[k-1];
			assign qi = quo_q[k-1];
			assign di = den_q[k-1];
			assign si = side_q[k-1];
		end

		// Shift in the next numerator bit and subtract if it fits.
		always_comb begin
			t  = {pi, ni[Q-1]};
			ge = t >= {1'b0, di};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_q[k] <= 1'b0;
			end else if (en) begin
				val_q[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				part_q[k] <= ge ? DW'(t - {1'b0, di}) : DW'(t);
				low_q[k]  <= {ni[Q-2:0], 1'b0};
				quo_q[k]  <= {qi[Q-2:0], ge};
				den_q[k]  <= di;
				side_q[k] <= si;
			end
		end
	end

	assign out_valid = val_q[Q-1];
	assign quo       = quo_q[Q-1];
	assign out_side  = side_q[Q-1];
endmodule

>>> sv/fresnel_dielectric_reflectance.sv
// Unpolarized Fresnel reflectance of a dielectric boundary, fully pipelined: one cosine word
// is accepted every cycle while in_ready is high. Both square-root units take COS_FRAC_BITS+1
// stages each, the Snell divider COS_FRAC_BITS stages, the ratio dividers 17 stages, and there
// are 10 arithmetic stages plus the output register. The whole pipeline advances together;
// when the output word is not taken, input ready drops until it is. The user must write
// eta_outside and eta_inside (index 0 and 1) only while the pipeline is empty; the block does
// not enforce this. Depends on fdr_pkg, fdr_isqrt, fdr_div and the defines header.
`include "fresnel_dielectric_reflectance_defines.svh"

module fresnel_dielectric_reflectance
	import fdr_pkg::*;
#(
	parameter int COS_FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [0:0]              cfg_index,
	input  logic [ETA_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [COS_W-1:0] cos_incident,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [REFL_W-1:0]       reflectance,
	output logic                    total_reflection
);
	localparam int F    = COS_FRAC_BITS;
	localparam int XW   = (F + 2 > COS_W) ? F + 2 : COS_W;
	localparam int AW   = F + 1;
	localparam int RW   = 2 * F + 2;
	localparam int PW   = ETA_W + AW;
	localparam int DENW = PW + 1;
	localparam int RNW  = PW + FRAC_OUT;
	localparam int SQW  = 2 * REFL_W;
	localparam int S1W  = 2 * ETA_W + AW;
	localparam int S2W  = S1W + 2;
	localparam int S3W  = S1W + 1;
	localparam logic signed [XW-1:0] ONE_X  = XW'(1 << F);
	localparam logic [RW-1:0]        ONE_SQ = RW'(64'd1 << (2 * F));

	logic [ETA_W-1:0] eta_outside_q, eta_inside_q;
	logic adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_outside_q <= 16'd4096;
			eta_inside_q  <= 16'd6144;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ETA_OUTSIDE: eta_outside_q <= cfg_data;
				REG_ETA_INSIDE:  eta_inside_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// All stages move together whenever the output register can take a word.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: clamp the cosine and pick the indices by direction.
	logic signed [XW-1:0] c_x, c_cl, c_mag;
	logic                 entering;
	always_comb begin
		c_x  = XW'(cos_incident);
		c_cl = c_x;
		if (c_x > ONE_X) begin
			c_cl = ONE_X;
		end
		if (c_x < -ONE_X) begin
			c_cl = -ONE_X;
		end
		entering = c_cl > 0;
		c_mag    = (c_cl < 0) ? -c_cl : c_cl;
	end

	logic v_s1;
	logic [AW-1:0] ac_s1;
	logic [ETA_W-1:0] ei_s1, et_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			ac_s1 <= c_mag[AW-1:0];
			ei_s1 <= entering ? eta_outside_q : eta_inside_q;
			et_s1 <= entering ? eta_inside_q : eta_outside_q;
		end
	end

	// Stage 2: square of the cosine.
	logic v_s2;
	logic [RW-1:0] acsq_s2;
	logic [AW-1:0] ac_s2;
	logic [ETA_W-1:0] ei_s2, et_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			acsq_s2 <= ac_s1 * ac_s1;
			ac_s2   <= ac_s1;
			ei_s2   <= ei_s1;
			et_s2   <= et_s1;
		end
	end

	// Stage 3: radicand of the incident sine.
	logic v_s3;
	logic [RW-1:0] rad_s3;
	logic [S1W-1:0] side_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3  <= ONE_SQ - acsq_s2;
			side_s3 <= {ei_s2, et_s2, ac_s2};
		end
	end

	logic v_si;
	logic [AW-1:0] sin_i;
	logic [S1W-1:0] side_si;
	fdr_isqrt #(.N(AW), .SW(S1W)) u_sqrt_sin (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s3), .rad(rad_s3), .in_side(side_s3),
		.out_valid(v_si), .root(sin_i), .out_side(side_si)
	);

	// Stage 4: Snell numerator.
	logic v_s4;
	logic [PW-1:0] numt_s4;
	logic [S1W-1:0] side_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			numt_s4 <= side_si[S1W-1 -: ETA_W] * sin_i;
			side_s4 <= side_si;
		end
	end

	// Stage 5: total internal reflection test, before the quotient.
	logic [ETA_W-1:0] et_4;
	assign et_4 = side_s4[AW +: ETA_W];

	logic v_s5;
	logic [PW-1:0] numt_s5;
	logic [ETA_W-1:0] et_s5;
	logic [S2W-1:0] side_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			numt_s5 <= numt_s4;
			et_s5   <= et_4;
			side_s5 <= {side_s4,
				(et_4 == '0) ? (numt_s4 != '0) : (numt_s4 >= PW'({et_4, {F{1'b0}}})),
				et_4 == '0};
		end
	end

	logic v_st;
	logic [F-1:0] sin_q;
	logic [S2W-1:0] side_st;
	fdr_div #(.NW(PW), .DW(ETA_W), .Q(F), .SW(S2W)) u_div_snell (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s5), .num(numt_s5), .den(et_s5), .in_side(side_s5),
		.out_valid(v_st), .quo(sin_q), .out_side(side_st)
	);

	// Stage 6: square of the transmitted sine; a zero transmitted index gives a zero sine.
	logic [F-1:0] sin_t;
	assign sin_t = side_st[0] ? '0 : sin_q;

	logic v_s6;
	logic [2*F-1:0] sinsq_s6;
	logic [S3W-1:0] side_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			sinsq_s6 <= sin_t * sin_t;
			side_s6  <= side_st[S2W-1:1];
		end
	end

	// Stage 7: radicand of the transmitted cosine.
	logic v_s7;
	logic [RW-1:0] radt_s7;
	logic [S3W-1:0] side_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			radt_s7 <= ONE_SQ - RW'(sinsq_s6);
			side_s7 <= side_s6;
		end
	end

	logic v_ct;
	logic [AW-1:0] cos_t;
	logic [S3W-1:0] side_ct;
	fdr_isqrt #(.N(AW), .SW(S3W)) u_sqrt_cos (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s7), .rad(radt_s7), .in_side(side_s7),
		.out_valid(v_ct), .root(cos_t), .out_side(side_ct)
	);

	// Stage 8: the four products of the amplitude ratios.
	logic [ETA_W-1:0] ei_c, et_c;
	logic [AW-1:0] ac_c;
	assign ei_c = side_ct[S3W-1 -: ETA_W];
	assign et_c = side_ct[AW+1 +: ETA_W];
	assign ac_c = side_ct[1 +: AW];

	logic v_s8, tir_s8;
	logic [PW-1:0] apar_s8, bpar_s8, aperp_s8, bperp_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			apar_s8  <= et_c * ac_c;
			bpar_s8  <= ei_c * cos_t;
			aperp_s8 <= ei_c * ac_c;
			bperp_s8 <= et_c * cos_t;
			tir_s8   <= side_ct[0];
		end
	end

	// Stage 9: sums and differences of the ratio terms.
	logic v_s9, tir_s9, dzpar_s9, dzperp_s9;
	logic [DENW-1:0] denpar_s9, denperp_s9;
	logic [PW-1:0] magpar_s9, magperp_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			denpar_s9  <= DENW'(apar_s8) + DENW'(bpar_s8);
			denperp_s9 <= DENW'(aperp_s8) + DENW'(bperp_s8);
			magpar_s9  <= (apar_s8 > bpar_s8) ? apar_s8 - bpar_s8 : bpar_s8 - apar_s8;
			magperp_s9 <= (aperp_s8 > bperp_s8) ? aperp_s8 - bperp_s8 : bperp_s8 - aperp_s8;
			dzpar_s9   <= (apar_s8 == '0) && (bpar_s8 == '0);
			dzperp_s9  <= (aperp_s8 == '0) && (bperp_s8 == '0);
			tir_s9     <= tir_s8;
		end
	end

	logic v_qp, v_qs;
	logic [REFL_W-1:0] qpar, qperp;
	logic [1:0] side_qp;
	logic side_qs;
	fdr_div #(.NW(RNW), .DW(DENW), .Q(REFL_W), .SW(2)) u_div_par (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s9), .num({magpar_s9, {FRAC_OUT{1'b0}}}), .den(denpar_s9),
		.in_side({tir_s9, dzpar_s9}),
		.out_valid(v_qp), .quo(qpar), .out_side(side_qp)
	);
	fdr_div #(.NW(RNW), .DW(DENW), .Q(REFL_W), .SW(1)) u_div_perp (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s9), .num({magperp_s9, {FRAC_OUT{1'b0}}}), .den(denperp_s9),
		.in_side(dzperp_s9),
		.out_valid(v_qs), .quo(qperp), .out_side(side_qs)
	);

	// Stage 10: squares of the ratios; a zero denominator counts as one.
	logic [REFL_W-1:0] qp, qs;
	assign qp = side_qp[0] ? REFL_ONE : qpar;
	assign qs = side_qs ? REFL_ONE : qperp;

	logic v_s10, tir_s10;
	logic [SQW-1:0] sqp_s10, sqs_s10;
	always_ff @(posedge clk) begin
		if (adv) begin
			sqp_s10 <= qp * qp;
			sqs_s10 <= qs * qs;
			tir_s10 <= side_qp[1];
		end
	end

	// Output register: mean of the squares, saturated, or one on total reflection.
	logic [SQW:0] sum;
	logic [SQW-REFL_W:0] r_full;
	assign sum    = (SQW+1)'(sqp_s10) + (SQW+1)'(sqs_s10);
	assign r_full = sum[SQW:REFL_W];

	logic out_valid_q, tir_q;
	logic [REFL_W-1:0] refl_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			tir_q <= tir_s10;
			if (tir_s10 || (r_full > (SQW-REFL_W+1)'(REFL_ONE))) begin
				refl_q <= REFL_ONE;
			end else begin
				refl_q <= r_full[REFL_W-1:0];
			end
		end
	end

	// Valid bits of the arithmetic stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_si;
			v_s5 <= v_s4;
			v_s6 <= v_st;
			v_s7 <= v_s6;
			v_s8 <= v_ct;
			v_s9 <= v_s8;
			v_s10 <= v_qp && v_qs;
			out_valid_q <= v_s10;
		end
	end

	assign out_valid        = out_valid_q;
	assign reflectance      = refl_q;
	assign total_reflection = tir_q;

	`FDR_ASSERT_IMP(a_tir_is_one, out_valid && total_reflection, reflectance == REFL_ONE)
	`FDR_ASSERT_IMP(a_refl_range, out_valid, reflectance <= REFL_ONE)
	`FDR_ASSERT_IMP(a_no_take_on_stall, out_valid && !out_ready, !in_ready)
	`FDR_ASSERT(a_ratio_lanes_agree, v_qp == v_qs)
endmodule
